// ===== src/fcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrd_pkg: shared types and constants for the fisheye-corrected ray distance
// Fixed-point formats, CORDIC constants, arctangent table and the record that
// travels down the row of CORDIC cells.
// ----------------------------------------------------------------------------
package fcrd_pkg;

  // Number of CORDIC cells in the row (legal range 8 to 24)
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int STAGE_W       = $clog2(CORDIC_STAGES);
  localparam int TABLE_W       = $clog2(TABLE_LEN);

  // Field widths
  localparam int POS_W       = 28;
  localparam int ANG_W       = 21;
  localparam int DIST_W      = 29;
  localparam int FLOOR_W     = 16;
  localparam int LIMIT_W     = 10;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  // Internal widths
  localparam int VEC_W   = 34;   // vectoring lane x/y, signed
  localparam int MAGX_W  = 32;   // final vectoring x never exceeds this
  localparam int ROT_W   = 33;   // rotation lane x/y, signed
  localparam int ZANG_W  = 33;   // residual angle in Q.30, signed
  localparam int WRAP_W  = 24;   // biased angle difference during wrap
  localparam int MAG_W   = 18;   // folded angle magnitude, 0..pi
  localparam int KMUL_W  = 30;
  localparam int Q30_SHIFT = 14;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_FLOOR   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SMALL_ANGLE = 1'b1;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd13107;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd7;

  // Angle constants in Q.16
  localparam logic [WRAP_W-1:0] ANG_PI      = 24'd205887;
  localparam logic [WRAP_W-1:0] ANG_HALF_PI = 24'd102944;
  localparam logic [WRAP_W-1:0] ANG_TWO_PI  = 24'd411775;
  // pi plus six turns: keeps the biased difference non-negative
  localparam logic [WRAP_W-1:0] WRAP_BIAS   = 24'd2676537;

  // CORDIC gain compensation in Q.30
  localparam logic [KMUL_W-1:0] CORDIC_K = 30'd652032874;

  localparam logic [DIST_W-1:0] OUT_MAX = '1;

  // atan(2^-i) in Q.30, truncated
  localparam logic signed [ZANG_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
    33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
    33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
    33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
    33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
    33'sd1023,      33'sd511,       33'sd255,       33'sd127
  };

  // Record carried from cell to cell
  typedef struct packed {
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic signed [ROT_W-1:0]  rx;
    logic signed [ROT_W-1:0]  ry;
    logic signed [ZANG_W-1:0] rz;
    logic                     neg;
    logic                     raw_only;
  } cord_t;

endpackage

// ===== src/fcrd_front.sv =====
// ----------------------------------------------------------------------------
// fcrd_front: operand preparation stage
// Forms |dx| and |dy|, wraps the angle difference into [-pi, pi], folds it
// into [0, pi/2] and seeds both CORDIC lanes.
// ----------------------------------------------------------------------------
module fcrd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fcrd_pkg::POS_W-1:0]          hit_pos_x,
  input  logic [fcrd_pkg::POS_W-1:0]          hit_pos_y,
  input  logic [fcrd_pkg::POS_W-1:0]          viewer_pos_x,
  input  logic [fcrd_pkg::POS_W-1:0]          viewer_pos_y,
  input  logic signed [fcrd_pkg::ANG_W-1:0]   ray_direction,
  input  logic signed [fcrd_pkg::ANG_W-1:0]   viewer_heading,
  input  logic [fcrd_pkg::LIMIT_W-1:0]        small_angle_limit,
  output logic                                dst_valid,
  output fcrd_pkg::cord_t                     dst_cord,
  input  logic                                dst_hold
);
  import fcrd_pkg::*;

  logic signed [POS_W:0]   dx;
  logic signed [POS_W:0]   dy;
  logic [POS_W-1:0]        adx;
  logic [POS_W-1:0]        ady;
  logic signed [ANG_W:0]   diff;
  logic [WRAP_W-1:0]       wrap;
  logic [WRAP_W-1:0]       mag_wide;
  logic [MAG_W-1:0]        angle_mag;
  logic [MAG_W-1:0]        fold;
  logic                    obtuse;
  cord_t                   cord_next;

  // Take a new transaction whenever this stage is empty or moving on
  assign in_ready = !(dst_valid && dst_hold);

  // Coordinate differences and their magnitudes
  always_comb begin
    dx  = $signed({1'b0, hit_pos_x}) - $signed({1'b0, viewer_pos_x});
    dy  = $signed({1'b0, hit_pos_y}) - $signed({1'b0, viewer_pos_y});
    adx = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    ady = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
  end

  // Wrap the difference: bias it positive, reduce modulo one turn, unbias
  always_comb begin
    diff = (ANG_W+1)'(ray_direction) - (ANG_W+1)'(viewer_heading);
    wrap = WRAP_W'(diff) + WRAP_BIAS;
    for (int k = 3; k >= 0; k--) begin
      if (wrap >= (ANG_TWO_PI << k)) begin
        wrap = wrap - (ANG_TWO_PI << k);
      end
    end
    mag_wide  = (wrap >= ANG_PI) ? (wrap - ANG_PI) : (ANG_PI - wrap);
    angle_mag = mag_wide[MAG_W-1:0];
    obtuse    = angle_mag > MAG_W'(ANG_HALF_PI);
    fold      = obtuse ? (MAG_W'(ANG_PI) - angle_mag) : angle_mag;
  end

  // Seed both lanes
  always_comb begin
    cord_next.vx       = VEC_W'({adx, 2'b00});
    cord_next.vy       = VEC_W'({ady, 2'b00});
    cord_next.rx       = ROT_W'(CORDIC_K);
    cord_next.ry       = '0;
    cord_next.rz       = ZANG_W'({fold, {Q30_SHIFT{1'b0}}});
    cord_next.neg      = obtuse;
    cord_next.raw_only = angle_mag < MAG_W'(small_angle_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (in_ready) begin
      dst_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      dst_cord <= cord_next;
    end
  end

endmodule

// ===== src/fcrd_cell.sv =====
// ----------------------------------------------------------------------------
// fcrd_cell: one CORDIC iteration for both lanes
// Vectoring lane drives y towards zero for the magnitude; rotation lane
// drives the residual angle towards zero for the cosine.
// ----------------------------------------------------------------------------
module fcrd_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fcrd_pkg::STAGE_W-1:0]  stage,
  input  logic                          src_valid,
  input  fcrd_pkg::cord_t               src_cord,
  output logic                          src_hold,
  output logic                          dst_valid,
  output fcrd_pkg::cord_t               dst_cord,
  input  logic                          dst_hold
);
  import fcrd_pkg::*;

  logic signed [VEC_W-1:0]  vxs;
  logic signed [VEC_W-1:0]  vys;
  logic signed [ROT_W-1:0]  rxs;
  logic signed [ROT_W-1:0]  rys;
  logic signed [ZANG_W-1:0] atan;
  logic                     advance;
  cord_t                    cord_next;

  // Stall only when full and the neighbour downstream is stalled
  assign src_hold = dst_valid && dst_hold;
  assign advance  = !src_hold;

  always_comb begin
    vxs  = src_cord.vx >>> stage;
    vys  = src_cord.vy >>> stage;
    rxs  = src_cord.rx >>> stage;
    rys  = src_cord.ry >>> stage;
    atan = ATAN_Q30[TABLE_W'(stage)];
    cord_next = src_cord;
    // Vectoring: rotate towards the x axis
    if (!src_cord.vy[VEC_W-1] && (src_cord.vy != '0)) begin
      cord_next.vx = src_cord.vx + vys;
      cord_next.vy = src_cord.vy - vxs;
    end else begin
      cord_next.vx = src_cord.vx - vys;
      cord_next.vy = src_cord.vy + vxs;
    end
    // Rotation: consume the residual angle
    if (!src_cord.rz[ZANG_W-1]) begin
      cord_next.rx = src_cord.rx - rys;
      cord_next.ry = src_cord.ry + rxs;
      cord_next.rz = src_cord.rz - atan;
    end else begin
      cord_next.rx = src_cord.rx + rys;
      cord_next.ry = src_cord.ry - rxs;
      cord_next.rz = src_cord.rz + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dst_cord <= cord_next;
    end
  end

endmodule

// ===== src/fcrd_back.sv =====
// ----------------------------------------------------------------------------
// fcrd_back: gain correction, cosine product, floor and output register
// Four registered steps: gain multiply, rounding, cosine multiply, then
// rounding, floor and saturation into the output register.
// ----------------------------------------------------------------------------
module fcrd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          src_valid,
  input  fcrd_pkg::cord_t               src_cord,
  output logic                          src_hold,
  input  logic [fcrd_pkg::FLOOR_W-1:0]  min_distance_floor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fcrd_pkg::DIST_W-1:0]   corrected_distance,
  output logic                          floor_applied
);
  import fcrd_pkg::*;

  localparam int PK_W = MAGX_W + KMUL_W;
  localparam int PC_W = DIST_W + 1 + ROT_W;
  localparam int V_W  = PC_W - 30;

  logic [2:0]               vld;
  logic [2:0]               hold;
  logic                     out_hold;

  logic [PK_W-1:0]          a_prod_k;
  logic signed [ROT_W-1:0]  a_cos;
  logic                     a_small;
  logic [PK_W-1:0]          a_round;

  logic [DIST_W-1:0]        b_raw;
  logic signed [ROT_W-1:0]  b_cos;
  logic                     b_small;

  logic signed [PC_W-1:0]   c_prod;
  logic [DIST_W-1:0]        c_raw;
  logic                     c_small;

  logic signed [PC_W-1:0]   c_round;
  logic signed [V_W-1:0]    v;
  logic                     raise;
  logic                     over;
  logic [DIST_W-1:0]        dist_next;

  // Stall chain: each step holds only if full and the next one holds
  assign out_hold = out_valid && !out_ready;
  assign hold[2]  = vld[2] && out_hold;
  assign hold[1]  = vld[1] && hold[2];
  assign hold[0]  = vld[0] && hold[1];
  assign src_hold = hold[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!hold[0]) vld[0] <= src_valid;
      if (!hold[1]) vld[1] <= vld[0];
      if (!hold[2]) vld[2] <= vld[1];
      if (!out_hold) out_valid <= vld[2];
    end
  end

  // Gain multiply; apply the sign for an obtuse difference
  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      a_prod_k <= PK_W'(src_cord.vx[MAGX_W-1:0]) * PK_W'(CORDIC_K);
      a_cos    <= src_cord.neg ? -src_cord.rx : src_cord.rx;
      a_small  <= src_cord.raw_only;
    end
  end

  // Round half up to Q.16 raw distance
  assign a_round = a_prod_k + (PK_W'(1) << 31);

  always_ff @(posedge clk) begin
    if (!hold[1]) begin
      b_raw   <= a_round[32 +: DIST_W];
      b_cos   <= a_cos;
      b_small <= a_small;
    end
  end

  // Multiply raw distance by the cosine
  always_ff @(posedge clk) begin
    if (!hold[2]) begin
      c_prod  <= PC_W'($signed({1'b0, b_raw})) * PC_W'(b_cos);
      c_raw   <= b_raw;
      c_small <= b_small;
    end
  end

  // Round, pick raw for small angles, floor and saturate
  always_comb begin
    c_round   = c_prod + (PC_W'(1) << 29);
    v         = c_small ? $signed(V_W'(c_raw)) : c_round[PC_W-1:30];
    raise     = v < $signed(V_W'(min_distance_floor));
    over      = v > $signed(V_W'(OUT_MAX));
    if (raise) begin
      dist_next = DIST_W'(min_distance_floor);
    end else if (over) begin
      dist_next = OUT_MAX;
    end else begin
      dist_next = v[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold) begin
      corrected_distance <= dist_next;
      floor_applied      <= raise;
    end
  end

  // The vectoring x result is non-negative and fits the gain multiplier
  a_vec_x_range: assert property (@(posedge clk) disable iff (rst)
    src_valid |-> (src_cord.vx[VEC_W-1:MAGX_W] == '0))
    else $error("vectoring x out of range");

  // A stalled rounding step keeps its contents
  a_step_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && hold[1]) |=> (vld[1] && $stable(b_raw) && $stable(b_cos)))
    else $error("stalled step lost its contents");

  // A floored result never exceeds the floor register's range
  a_floor_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && floor_applied) |-> (corrected_distance[DIST_W-1:FLOOR_W] == '0))
    else $error("floored result out of range");

endmodule

// ===== src/fisheye_corrected_ray_distance.sv =====
// ----------------------------------------------------------------------------
// fisheye_corrected_ray_distance: perpendicular wall distance for one column
// Euclidean distance by vectoring CORDIC, scaled by the cosine of the wrapped
// ray-to-heading angle by rotation CORDIC, floored and saturated.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while in_ready is high and
// returns one result per transaction, in order. Operand preparation is
// registered, each cell in the row of CORDIC cells, which run the magnitude
// and cosine iterations side by side, is registered, and the multiply,
// rounding and flooring steps end in the output register. A stall reaches back
// only through stages that hold a transaction, so empty stages keep filling
// and in_ready stays high while a finished result waits, until every stage is
// full. Configuration writes take effect at once and are meant to happen while
// no transaction is in flight.
// ----------------------------------------------------------------------------
module fisheye_corrected_ray_distance (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [fcrd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fcrd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fcrd_pkg::POS_W-1:0]           hit_pos_x,
  input  logic [fcrd_pkg::POS_W-1:0]           hit_pos_y,
  input  logic [fcrd_pkg::POS_W-1:0]           viewer_pos_x,
  input  logic [fcrd_pkg::POS_W-1:0]           viewer_pos_y,
  input  logic signed [fcrd_pkg::ANG_W-1:0]    ray_direction,
  input  logic signed [fcrd_pkg::ANG_W-1:0]    viewer_heading,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fcrd_pkg::DIST_W-1:0]          corrected_distance,
  output logic                                 floor_applied
);
  import fcrd_pkg::*;

  logic [FLOOR_W-1:0] min_distance_floor;
  logic [LIMIT_W-1:0] small_angle_limit;

  logic  chain_valid [CORDIC_STAGES+1];
  cord_t chain_cord  [CORDIC_STAGES+1];
  logic  chain_hold  [CORDIC_STAGES+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance_floor <= FLOOR_RESET;
      small_angle_limit  <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_FLOOR:   min_distance_floor <= cfg_data[FLOOR_W-1:0];
        REG_SMALL_ANGLE: small_angle_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand preparation
  fcrd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .hit_pos_x         (hit_pos_x),
    .hit_pos_y         (hit_pos_y),
    .viewer_pos_x      (viewer_pos_x),
    .viewer_pos_y      (viewer_pos_y),
    .ray_direction     (ray_direction),
    .viewer_heading    (viewer_heading),
    .small_angle_limit (small_angle_limit),
    .dst_valid         (chain_valid[0]),
    .dst_cord          (chain_cord[0]),
    .dst_hold          (chain_hold[0])
  );

  // Row of CORDIC cells
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    fcrd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (STAGE_W'(g)),
      .src_valid (chain_valid[g]),
      .src_cord  (chain_cord[g]),
      .src_hold  (chain_hold[g]),
      .dst_valid (chain_valid[g+1]),
      .dst_cord  (chain_cord[g+1]),
      .dst_hold  (chain_hold[g+1])
    );
  end

  // Gain correction, cosine product and output register
  fcrd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .src_valid          (chain_valid[CORDIC_STAGES]),
    .src_cord           (chain_cord[CORDIC_STAGES]),
    .src_hold           (chain_hold[CORDIC_STAGES]),
    .min_distance_floor (min_distance_floor),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .corrected_distance (corrected_distance),
    .floor_applied      (floor_applied)
  );

endmodule

// ===== tb/sv/fisheye_corrected_ray_distance_checker.sv =====
// ----------------------------------------------------------------------------
// fisheye_corrected_ray_distance_checker: distance predictor and scoreboard
// Follows the register writes, predicts the floored, fisheye-corrected
// distance of every accepted transaction with a CORDIC of its own and
// compares each returned result, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module fisheye_corrected_ray_distance_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fcrd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fcrd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [fcrd_pkg::POS_W-1:0]          hit_pos_x,
  input  logic [fcrd_pkg::POS_W-1:0]          hit_pos_y,
  input  logic [fcrd_pkg::POS_W-1:0]          viewer_pos_x,
  input  logic [fcrd_pkg::POS_W-1:0]          viewer_pos_y,
  input  logic signed [fcrd_pkg::ANG_W-1:0]   ray_direction,
  input  logic signed [fcrd_pkg::ANG_W-1:0]   viewer_heading,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [fcrd_pkg::DIST_W-1:0]         corrected_distance,
  input  logic                                floor_applied,
  output int                                  mismatches,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fcrd_pkg::*;

  // Angles in Q.16 radians, gain in Q.30
  localparam longint PI_Q16      = 205887;
  localparam longint HALF_PI_Q16 = 102944;
  localparam longint TWO_PI_Q16  = 411775;
  localparam longint GAIN_Q30    = 652032874;
  localparam longint DIST_LIMIT  = (64'sd1 <<< DIST_W) - 1;
  localparam int     ROUNDS      = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

  localparam logic [FLOOR_W-1:0] FLOOR_DEFAULT = 16'd13107;
  localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 10'd7;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              floor_hit;
  } distance_result_t;

  // atan(2^-i) in Q.30, truncated
  longint arctan_q30 [24] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686,  33543515,  16775850,  8388437,
    4194282,   2097149,   1048575,   524287,
    262143,    131071,    65535,     32767,
    16383,     8191,      4095,      2047,
    1023,      511,       255,       127
  };

  logic [FLOOR_W-1:0] floor_q16;
  logic [LIMIT_W-1:0] limit_q16;
  distance_result_t   distance_q [$];
  int                 results_seen;

  // Euclidean length of a non-negative vector, Q.16 in and out
  function automatic longint vector_length(input longint ax, input longint ay);
    longint x, y, xs, ys;
    x = ax * 4;
    y = ay * 4;
    for (int i = 0; i < ROUNDS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
      end else begin
        x = x - ys;
        y = y + xs;
      end
    end
    return (x * GAIN_Q30 + (64'sd1 <<< 31)) >>> 32;
  endfunction

  // Cosine in Q.30 of an angle between 0 and pi/2 given in Q.16
  function automatic longint cos_q30(input longint ang);
    longint x, y, z, xs, ys;
    x = GAIN_Q30;
    y = 0;
    z = ang * 16384;
    for (int i = 0; i < ROUNDS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q30[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q30[i];
      end
    end
    return x;
  endfunction

  function automatic distance_result_t corrected_distance_of(
    input logic [POS_W-1:0]        hx,
    input logic [POS_W-1:0]        hy,
    input logic [POS_W-1:0]        vx,
    input logic [POS_W-1:0]        vy,
    input logic signed [ANG_W-1:0] ray,
    input logic signed [ANG_W-1:0] head
  );
    longint dx, dy, diff, raw_len, ang, cosv, prod;
    distance_result_t r;
    dx   = longint'(hx) - longint'(vx);
    dy   = longint'(hy) - longint'(vy);
    diff = longint'(ray) - longint'(head);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    raw_len = vector_length(dx, dy);

    // Wrap the view angle difference into [-pi, pi]
    while (diff > PI_Q16) diff = diff - TWO_PI_Q16;
    while (diff < -PI_Q16) diff = diff + TWO_PI_Q16;
    ang = (diff < 0) ? -diff : diff;

    if (ang < longint'(limit_q16)) begin
      prod = raw_len;
    end else begin
      // Obtuse angles fold back onto the first quadrant with a negated cosine
      if (ang > HALF_PI_Q16) cosv = -cos_q30(PI_Q16 - ang);
      else cosv = cos_q30(ang);
      prod = (raw_len * cosv + (64'sd1 <<< 29)) >>> 30;
    end

    r.floor_hit = 1'b0;
    if (prod < longint'(floor_q16)) begin
      prod = longint'(floor_q16);
      r.floor_hit = 1'b1;
    end
    if (prod > DIST_LIMIT) prod = DIST_LIMIT;
    r.distance = prod[DIST_W-1:0];
    return r;
  endfunction

  // Follow register writes, predict on input transactions, check on output
  always @(posedge clk) begin : score
    distance_result_t want;
    if (rst) begin
      floor_q16 = FLOOR_DEFAULT;
      limit_q16 = LIMIT_DEFAULT;
      distance_q.delete();
      mismatches   = 0;
      pending      = 0;
      results_seen = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MIN_FLOOR) floor_q16 = cfg_data[FLOOR_W-1:0];
        else if (cfg_index == REG_SMALL_ANGLE) limit_q16 = cfg_data[LIMIT_W-1:0];
      end

      if (in_valid && in_ready) begin
        distance_q.push_back(corrected_distance_of(hit_pos_x, hit_pos_y, viewer_pos_x,
                                                   viewer_pos_y, ray_direction,
                                                   viewer_heading));
      end

      if (out_valid && out_ready) begin
        if (distance_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %0d arrived with no transaction outstanding: dist=%0d flag=%0d",
                     $realtime, results_seen, corrected_distance, floor_applied);
          mismatches++;
        end else begin
          want = distance_q.pop_front();
          if (corrected_distance !== want.distance || floor_applied !== want.floor_hit) begin
            if (mismatches < 10)
              $display("%0t: result %0d: expected dist=%0d flag=%0d, got dist=%0d flag=%0d",
                       $realtime, results_seen, want.distance, want.floor_hit,
                       corrected_distance, floor_applied);
            mismatches++;
          end
        end
        results_seen++;
      end
      pending = distance_q.size();
    end
  end

endmodule

// ===== tb/sv/fisheye_corrected_ray_distance_tb.sv =====
// ----------------------------------------------------------------------------
// fisheye_corrected_ray_distance_tb: regression for the corrected ray distance
// Drives directed corner cases and then randomised rays through four phases
// of register settings and handshake idling, including one long output
// hold-off that fills the pipeline. The checker beside the block predicts and
// scores every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module fisheye_corrected_ray_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W = fcrd_pkg::POS_W;
  localparam int ANG_W = fcrd_pkg::ANG_W;

  localparam logic [POS_W-1:0] POS_MAX  = '1;
  localparam int unsigned      MAP_SPAN = (64 << 16) - 1;
  localparam int               FOV_Q16  = 39321;
  localparam int               HALF_PI  = 102944;
  localparam int               PI_Q16   = 205887;
  localparam int               TWO_PI   = 411775;
  localparam logic signed [ANG_W-1:0] ANG_MIN = 21'sh100000;
  localparam logic signed [ANG_W-1:0] ANG_MAX = 21'sd1048575;

  // A typical geometry for the angle corner cases
  localparam logic [POS_W-1:0] HIT_X = 28'd1310720;
  localparam logic [POS_W-1:0] HIT_Y = 28'd1998848;
  localparam logic [POS_W-1:0] EYE_X = 28'd212992;
  localparam logic [POS_W-1:0] EYE_Y = 28'd507904;

  localparam int ITEMS_PER_PHASE = 285;
  localparam int HOLD_CYCLES     = 120;

  logic                              clk;
  logic                              rst;
  logic                              cfg_write;
  logic [fcrd_pkg::CFG_INDEX_W-1:0]  cfg_index;
  logic [fcrd_pkg::CFG_DATA_W-1:0]   cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic [POS_W-1:0]                  hit_pos_x;
  logic [POS_W-1:0]                  hit_pos_y;
  logic [POS_W-1:0]                  viewer_pos_x;
  logic [POS_W-1:0]                  viewer_pos_y;
  logic signed [ANG_W-1:0]           ray_direction;
  logic signed [ANG_W-1:0]           viewer_heading;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [fcrd_pkg::DIST_W-1:0]       corrected_distance;
  logic                              floor_applied;

  int mismatch_count;
  int pending_results;
  int idle_pct  = 0;
  int stall_pct = 0;
  bit pressure_armed = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  fisheye_corrected_ray_distance u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .hit_pos_x          (hit_pos_x),
    .hit_pos_y          (hit_pos_y),
    .viewer_pos_x       (viewer_pos_x),
    .viewer_pos_y       (viewer_pos_y),
    .ray_direction      (ray_direction),
    .viewer_heading     (viewer_heading),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .corrected_distance (corrected_distance),
    .floor_applied      (floor_applied)
  );

  fisheye_corrected_ray_distance_checker u_distance_check (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .hit_pos_x          (hit_pos_x),
    .hit_pos_y          (hit_pos_y),
    .viewer_pos_x       (viewer_pos_x),
    .viewer_pos_y       (viewer_pos_y),
    .ray_direction      (ray_direction),
    .viewer_heading     (viewer_heading),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .corrected_distance (corrected_distance),
    .floor_applied      (floor_applied),
    .mismatches         (mismatch_count),
    .pending            (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once armed
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (pressure_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one transaction, idling first at random; valid stays high afterwards
  task automatic send_item(input logic [POS_W-1:0] hx, input logic [POS_W-1:0] hy,
                           input logic [POS_W-1:0] vx, input logic [POS_W-1:0] vy,
                           input logic signed [ANG_W-1:0] ray,
                           input logic signed [ANG_W-1:0] head);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid       <= 1'b1;
    hit_pos_x      <= hx;
    hit_pos_y      <= hy;
    viewer_pos_x   <= vx;
    viewer_pos_y   <= vy;
    ray_direction  <= ray;
    viewer_heading <= head;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_ray();
    logic [POS_W-1:0]        hx, hy, vx, vy;
    logic signed [ANG_W-1:0] ray, head;
    int unsigned             pos_mode, ang_mode;
    int                      offset;
    pos_mode = $urandom_range(9);
    ang_mode = $urandom_range(9);

    // Mostly a viewer and a wall inside a small map
    vx = POS_W'($urandom_range(MAP_SPAN));
    vy = POS_W'($urandom_range(MAP_SPAN));
    hx = POS_W'($urandom_range(MAP_SPAN));
    hy = POS_W'($urandom_range(MAP_SPAN));
    case (pos_mode)
      6: begin
        vx = POS_W'($urandom());
        vy = POS_W'($urandom());
        hx = POS_W'($urandom());
        hy = POS_W'($urandom());
      end
      7: begin
        hx = vx;
        hy = vy;
      end
      8: begin
        vx = $urandom_range(1) ? POS_MAX : '0;
        vy = $urandom_range(1) ? POS_MAX : '0;
        hx = $urandom_range(1) ? POS_MAX : POS_W'($urandom());
        hy = $urandom_range(1) ? '0 : POS_W'($urandom());
      end
      9: begin
        hx = vx ^ POS_W'($urandom_range(255));
        hy = vy ^ POS_W'($urandom_range(255));
      end
      default: ;
    endcase

    // Mostly rays inside the field of view around the heading
    head = ANG_W'($urandom());
    case (ang_mode)
      5: begin
        offset = int'($urandom_range(2200)) - 1100;
        ray = ANG_W'(head + offset);
      end
      6: ray = ANG_W'($urandom());
      7: begin
        case ($urandom_range(2))
          0: offset = HALF_PI;
          1: offset = PI_Q16;
          default: offset = TWO_PI;
        endcase
        offset = offset + int'($urandom_range(8)) - 4;
        if ($urandom_range(1)) offset = -offset;
        ray = ANG_W'(head + offset);
      end
      8: begin
        head = $urandom_range(1) ? ANG_MAX : ANG_MIN;
        ray  = $urandom_range(1) ? ANG_MAX : ANG_MIN;
      end
      default: begin
        offset = int'($urandom_range(2 * FOV_Q16)) - FOV_Q16;
        ray = ANG_W'(head + offset);
      end
    endcase
    send_item(hx, hy, vx, vy, ray, head);
  endtask

  // Drop valid and wait until every result is back and the pipe has emptied
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] floor_val, input logic [15:0] limit_val);
    cfg_write <= 1'b1;
    cfg_index <= fcrd_pkg::REG_MIN_FLOOR;
    cfg_data  <= floor_val;
    @(posedge clk);
    cfg_index <= fcrd_pkg::REG_SMALL_ANGLE;
    cfg_data  <= limit_val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_write      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    hit_pos_x      <= '0;
    hit_pos_y      <= '0;
    viewer_pos_x   <= '0;
    viewer_pos_y   <= '0;
    ray_direction  <= '0;
    viewer_heading <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed corners under the reset settings
    send_item('0, '0, '0, '0, '0, '0);
    send_item(POS_MAX, POS_MAX, '0, '0, '0, '0);
    send_item('0, '0, POS_MAX, POS_MAX, '0, '0);
    send_item(POS_MAX, '0, '0, POS_MAX, '0, '0);
    send_item(POS_MAX, EYE_Y, '0, EYE_Y, '0, '0);
    send_item(EYE_X, '0, EYE_X, POS_MAX, '0, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, 21'sd6, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, 21'sd7, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, -21'sd7, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, '0, 21'sd6);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, 21'sd102944, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, 21'sd102945, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, 21'sd154415, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, 21'sd205887, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, -21'sd205887, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, 21'sd205888, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, 21'sd411775, '0);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, ANG_MAX, ANG_MIN);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, ANG_MIN, ANG_MAX);
    send_item(HIT_X, HIT_Y, EYE_X, EYE_Y, ANG_MIN, ANG_MIN);

    // Random rays under four settings and four idling mixes
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_results();
      case (phase)
        0: set_config(16'd0, 16'd0);
        1: set_config(16'hFFFF, 16'hFFFF);
        2: set_config(16'd6554, 16'hFC40);
        default: set_config(16'($urandom()), 16'($urandom()));
      endcase
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold the output off while the sender keeps offering
        if (phase == 0 && n == 40) pressure_armed = 1'b1;
        send_random_ray();
      end
    end
    wait_for_results();

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
